[rtl/tlbt_pkg.sv]
`timescale 1ns / 1ps
package tlbt_pkg;
    localparam int unsigned CfgIdxW = 2;

    typedef enum logic [1:0] {
        ACT_TRANSLATE = 2'd0,
        ACT_FILL      = 2'd1,
        ACT_FLUSH     = 2'd2,
        ACT_NONE      = 2'd3
    } t_action;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_PAGE_SIZE   = 2'd0,
        CFG_ENTRIES_PT  = 2'd1,
        CFG_TLB_LIMIT   = 2'd2,
        CFG_POLICY      = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_PAGE,
        ST_DIV_TABLE,
        ST_SCAN_REQ,
        ST_SCAN,
        ST_DECIDE,
        ST_VICTIM_REQ,
        ST_VICTIM,
        ST_WRITE,
        ST_MUL,
        ST_OUT
    } t_state;

    // serial restoring divider: 32-bit dividend, divisor up to 17 bits
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [16:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [16:0] rem;
    } t_div_rsp;
endpackage

[rtl/tlbt_if.sv]
`timescale 1ns / 1ps
interface tlbt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] logical_address;
    logic [19:0] frame_in;
    modport source (output valid, action, logical_address, frame_in, input ready);
    modport sink   (input valid, action, logical_address, frame_in, output ready);
endinterface

interface tlbt_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [19:0] frame;
    logic [31:0] physical_address;
    logic [31:0] page_number;
    logic [31:0] first_level_index;
    logic [9:0]  second_level_index;
    logic [15:0] offset;
    logic        evicted_valid;
    logic [31:0] evicted_page;
    modport source (output valid, hit, frame, physical_address, page_number,
        first_level_index, second_level_index, offset, evicted_valid,
        evicted_page, input ready);
    modport sink (input valid, hit, frame, physical_address, page_number,
        first_level_index, second_level_index, offset, evicted_valid,
        evicted_page, output ready);
endinterface

interface tlbt_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [16:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/tlbt_divider.sv]
`timescale 1ns / 1ps
module tlbt_divider
    import tlbt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [31:0] r_quot;
    logic [17:0] r_rem;
    logic [16:0] r_div;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [17:0] w_shift;

    assign w_shift = {r_rem[16:0], r_quot[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_quot <= i_req.dividend;
                r_rem  <= '0;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                // one quotient bit per cycle
                if (w_shift >= {1'b0, r_div}) begin
                    r_rem  <= w_shift - {1'b0, r_div};
                    r_quot <= {r_quot[30:0], 1'b1};
                end else begin
                    r_rem  <= w_shift;
                    r_quot <= {r_quot[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem[16:0];
endmodule

[rtl/tlb_two_level_translation.sv]
`timescale 1ns / 1ps
// Two-level address translation with a fully associative TLB. Each transfer
// carries an action: translate, fill after a miss, or flush. The address is
// split by a serial divider, first into page and offset and then into the
// two table indices. The TLB memory is then scanned one entry a cycle through
// a registered read. On a replacing fill it is scanned once more for the FIFO
// or LRU victim. A hit writes the use stamp back and a fill writes the whole
// entry. One item is in flight at a time. A flush or an unknown action takes
// the same path through the divider and then skips the scan.
// The result waits in an output register until the sink takes it; the block
// then returns to idle and accepts the next transfer. Entry valid bits live
// in flops and are cleared at once by reset and flush, so no clearing pass
// is needed.
module tlb_two_level_translation
    import tlbt_pkg::*;
#(
    parameter int unsigned TLB_DEPTH  = 16,
    parameter int unsigned FRAME_BITS = 20
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    tlbt_in_if.sink    in_ch,
    tlbt_out_if.source out_ch,
    tlbt_cfg_if.sink   cfg_ch
);
    localparam int unsigned IdxW = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
    localparam int unsigned CntW = $clog2(TLB_DEPTH + 1);
    localparam int unsigned EntW = 32 + FRAME_BITS + 64;
    localparam logic [19:0] FrameMask = 20'((64'd1 << FRAME_BITS) - 64'd1);

    // configuration registers
    logic [16:0] r_page_size;
    logic [10:0] r_ept;
    logic [4:0]  r_limit_cfg;
    logic        r_policy;

    t_state r_state, n_state;

    logic [1:0]  r_action;
    logic [19:0] r_frame_in;
    logic [16:0] r_psz;
    logic [31:0] r_page;
    logic [15:0] r_off;
    logic [31:0] r_first;
    logic [9:0]  r_second;

    // TLB memory: page, frame, load stamp, use stamp
    logic [EntW-1:0] r_mem [TLB_DEPTH];
    logic [EntW-1:0] r_rd;
    logic [TLB_DEPTH-1:0] r_valid;
    logic [CntW-1:0] r_vcount;
    logic [31:0] r_event;

    logic [IdxW-1:0] r_ptr;     // read address
    logic [IdxW-1:0] r_ptr_d;   // address of data in r_rd
    logic            r_found;
    logic [IdxW-1:0] r_slot;
    logic            r_best_ok;
    logic [31:0]     r_best_load;
    logic [31:0]     r_best_use;
    logic [31:0]     r_best_page;
    logic            r_evict;
    logic [31:0]     r_ev_page;
    logic            r_hit;
    logic [19:0]     r_frame;
    logic [31:0]     r_phys;

    // output register
    logic        r_ovalid;

    t_div_req w_dreq;
    t_div_rsp w_drsp;

    tlbt_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    logic [31:0]     w_rd_page;
    logic [19:0]     w_rd_frame;
    logic [31:0]     w_rd_load;
    logic [31:0]     w_rd_use;
    logic            w_rd_valid;
    logic [CntW-1:0] w_limit;
    logic [10:0]     w_ept;
    logic            w_older;
    logic            w_scan_last;
    logic [IdxW-1:0] w_free;
    logic            w_free_ok;

    assign w_rd_page  = r_rd[EntW-1 -: 32];
    assign w_rd_frame = 20'(r_rd[64 +: FRAME_BITS]);
    assign w_rd_load  = r_rd[63:32];
    assign w_rd_use   = r_rd[31:0];
    assign w_rd_valid = r_valid[r_ptr_d];
    assign w_scan_last = (32'(r_ptr_d) == TLB_DEPTH - 1);

    // clamp the limit and table size
    always_comb begin
        if (r_limit_cfg == 5'd0) w_limit = CntW'(1);
        else if (32'(r_limit_cfg) > TLB_DEPTH) w_limit = CntW'(TLB_DEPTH);
        else w_limit = CntW'(r_limit_cfg);
        if (r_ept == 11'd0) w_ept = 11'd1;
        else if (r_ept > 11'd1024) w_ept = 11'd1024;
        else w_ept = r_ept;
    end

    // lowest invalid slot
    always_comb begin
        w_free    = '0;
        w_free_ok = 1'b0;
        for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free    = IdxW'(i);
                w_free_ok = 1'b1;
            end
        end
    end

    always_comb begin
        if (!r_policy || w_rd_use == r_best_use) w_older = w_rd_load < r_best_load;
        else w_older = w_rd_use < r_best_use;
    end

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = (r_state == ST_IDLE);

    always_comb begin
        w_dreq = '0;
        if (r_state == ST_IDLE && in_ch.valid) begin
            w_dreq.start    = 1'b1;
            w_dreq.dividend = in_ch.logical_address;
            if (r_page_size == 17'd0) w_dreq.divisor = 17'd1;
            else if (r_page_size > 17'd65536) w_dreq.divisor = 17'd65536;
            else w_dreq.divisor = r_page_size;
        end else if (r_state == ST_DIV_PAGE && w_drsp.done) begin
            w_dreq.start    = 1'b1;
            w_dreq.dividend = w_drsp.quot;
            w_dreq.divisor  = {6'd0, w_ept};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (in_ch.valid) n_state = ST_DIV_PAGE;
            ST_DIV_PAGE:  if (w_drsp.done) n_state = ST_DIV_TABLE;
            ST_DIV_TABLE: begin
                if (w_drsp.done) begin
                    if (r_action == ACT_TRANSLATE || r_action == ACT_FILL)
                        n_state = ST_SCAN_REQ;
                    else
                        n_state = ST_OUT;
                end
            end
            ST_SCAN_REQ:  n_state = ST_SCAN;
            ST_SCAN:      if (w_scan_last) n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (r_found) begin
                    n_state = (r_action == ACT_FILL) ? ST_WRITE :
                              (r_action == ACT_TRANSLATE) ? ST_WRITE : ST_MUL;
                end else if (r_action == ACT_FILL) begin
                    if (r_vcount < w_limit && w_free_ok) n_state = ST_WRITE;
                    else n_state = ST_VICTIM_REQ;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_VICTIM_REQ: n_state = ST_VICTIM;
            ST_VICTIM:     if (w_scan_last) n_state = ST_WRITE;
            ST_WRITE:      n_state = ST_MUL;
            ST_MUL:        n_state = ST_OUT;
            ST_OUT:        if (!r_ovalid) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    // memory port: one read, one write
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_ptr];
        if (r_state == ST_WRITE) begin
            if (r_action == ACT_FILL)
                r_mem[r_slot] <= {r_page, FRAME_BITS'(r_frame_in), r_event, 32'd0};
            else
                r_mem[r_slot] <= {r_best_page, FRAME_BITS'(r_frame), r_best_load,
                                  r_event};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size <= 17'd64;
            r_ept       <= 11'd4;
            r_limit_cfg <= 5'd4;
            r_policy    <= 1'b0;
            r_valid     <= '0;
            r_vcount    <= '0;
            r_event     <= 32'd1;
            r_ovalid    <= 1'b0;
        end else begin
            if (cfg_ch.valid) begin
                case (t_cfg_idx'(cfg_ch.index))
                    CFG_PAGE_SIZE:  r_page_size <= cfg_ch.data;
                    CFG_ENTRIES_PT: r_ept       <= cfg_ch.data[10:0];
                    CFG_TLB_LIMIT:  r_limit_cfg <= cfg_ch.data[4:0];
                    CFG_POLICY:     r_policy    <= cfg_ch.data[0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) r_ovalid <= 1'b0;

            case (r_state)
                ST_IDLE: begin
                    if (in_ch.valid) begin
                        r_action   <= in_ch.action;
                        r_frame_in <= in_ch.frame_in & FrameMask;
                        r_psz      <= w_dreq.divisor;
                    end
                end
                ST_DIV_PAGE: begin
                    if (w_drsp.done) begin
                        r_page <= w_drsp.quot;
                        r_off  <= w_drsp.rem[15:0];
                    end
                end
                ST_DIV_TABLE: begin
                    if (w_drsp.done) begin
                        r_first  <= w_drsp.quot;
                        r_second <= w_drsp.rem[9:0];
                        r_ptr    <= '0;
                        r_found  <= 1'b0;
                        r_hit    <= 1'b0;
                        r_frame  <= '0;
                        r_evict  <= 1'b0;
                        r_ev_page <= '0;
                        r_phys   <= '0;
                        if (r_action == ACT_FLUSH) begin
                            r_valid  <= '0;
                            r_vcount <= '0;
                        end
                    end
                end
                ST_SCAN_REQ, ST_VICTIM_REQ: begin
                    // first read issued, advance pointer
                    r_ptr_d   <= r_ptr;
                    r_ptr     <= r_ptr + IdxW'(1);
                    r_best_ok <= 1'b0;
                end
                ST_SCAN: begin
                    r_ptr_d <= r_ptr;
                    r_ptr   <= r_ptr + IdxW'(1);
                    if (w_rd_valid && w_rd_page == r_page && !r_found) begin
                        r_found     <= 1'b1;
                        r_slot      <= r_ptr_d;
                        r_best_page <= w_rd_page;
                        r_best_load <= w_rd_load;
                        r_frame     <= w_rd_frame;
                    end
                end
                ST_DECIDE: begin
                    r_ptr <= '0;
                    if (r_found) begin
                        r_hit <= 1'b1;
                    end else if (r_action == ACT_FILL && r_vcount < w_limit && w_free_ok) begin
                        r_slot   <= w_free;
                        r_vcount <= r_vcount + CntW'(1);
                    end
                end
                ST_VICTIM: begin
                    r_ptr_d <= r_ptr;
                    r_ptr   <= r_ptr + IdxW'(1);
                    if (w_rd_valid && (!r_best_ok || w_older)) begin
                        r_best_ok   <= 1'b1;
                        r_slot      <= r_ptr_d;
                        r_best_load <= w_rd_load;
                        r_best_use  <= w_rd_use;
                        r_ev_page   <= w_rd_page;
                        r_evict     <= 1'b1;
                    end
                end
                ST_WRITE: begin
                    if (r_action == ACT_FILL) begin
                        r_valid[r_slot] <= 1'b1;
                        r_hit   <= 1'b1;
                        r_frame <= r_frame_in;
                    end
                    r_event <= r_event + 32'd1;
                end
                ST_MUL: begin
                    r_phys <= 32'(r_frame) * 32'(r_psz) + {16'd0, r_off};
                end
                ST_OUT: ;
                default: ;
            endcase

            // a translate miss still advances time
            if (r_state == ST_DECIDE && !r_found && r_action == ACT_TRANSLATE)
                r_event <= r_event + 32'd1;
            if (r_state == ST_DIV_TABLE && w_drsp.done &&
                !(r_action == ACT_TRANSLATE || r_action == ACT_FILL))
                r_ovalid <= 1'b1;
            if (r_state == ST_DECIDE && !r_found && r_action == ACT_TRANSLATE)
                r_ovalid <= 1'b1;
            if (r_state == ST_MUL) r_ovalid <= 1'b1;
        end
    end

    // flush and unknown actions give an all-zero result
    logic w_zero;
    assign w_zero = !(r_action == ACT_TRANSLATE || r_action == ACT_FILL);

    assign out_ch.valid              = r_ovalid;
    assign out_ch.hit                = r_hit & !w_zero;
    assign out_ch.frame              = w_zero ? '0 : r_frame;
    assign out_ch.physical_address   = w_zero ? '0 : r_phys;
    assign out_ch.page_number        = w_zero ? '0 : r_page;
    assign out_ch.first_level_index  = w_zero ? '0 : r_first;
    assign out_ch.second_level_index = w_zero ? '0 : r_second;
    assign out_ch.offset             = w_zero ? '0 : r_off;
    assign out_ch.evicted_valid      = w_zero ? 1'b0 : r_evict;
    assign out_ch.evicted_page       = w_zero ? '0 : r_ev_page;
endmodule

[rtl/tlbt_checker.sv]
`timescale 1ns / 1ps
module tlbt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_hit,
    input logic [19:0] out_frame,
    input logic        out_evicted_valid
);
    // hold result while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    // no new transfer taken while a result waits
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input taken during result");
    // eviction implies a hit
    a_ev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_evicted_valid |-> out_hit) else $error("evict without hit");
    // a miss carries no frame
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_hit |-> out_frame == 20'd0) else $error("frame on miss");
    // accepted input is followed by busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready) else $error("ready after transfer");
endmodule

bind tlb_two_level_translation tlbt_checker u_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_hit          (out_ch.hit),
    .out_frame        (out_ch.frame),
    .out_evicted_valid(out_ch.evicted_valid)
);

[dv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import tlbt_pkg::*;

    localparam int unsigned DEPTH      = 16;
    localparam int unsigned CLK_HALF   = 6;
    localparam int unsigned STALL_MAX  = 8000;  // cycles without any transfer
    localparam int unsigned HOLD_LEN   = 2500;  // long receiver hold-off
    localparam int unsigned DRAIN_WAIT = 200;   // well over one item's latency
    localparam int unsigned POOL_SIZE  = 24;

    typedef struct packed {
        logic        hit;
        logic [19:0] frame;
        logic [31:0] phys;
        logic [31:0] page;
        logic [31:0] first_idx;
        logic [9:0]  second_idx;
        logic [15:0] offset;
        logic        ev_valid;
        logic [31:0] ev_page;
    } t_xlate_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tlbt_in_if  in_ch();
    tlbt_out_if out_ch();
    tlbt_cfg_if cfg_ch();

    tlb_two_level_translation #(.TLB_DEPTH(DEPTH), .FRAME_BITS(20)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Shadow copy of the block: configuration and TLB contents
    logic [16:0] sh_page_size;
    logic [10:0] sh_entries_pt;
    logic [4:0]  sh_limit;
    logic        sh_policy;
    logic        tlb_valid [DEPTH];
    logic [31:0] tlb_page  [DEPTH];
    logic [19:0] tlb_frame [DEPTH];
    logic [31:0] tlb_loaded[DEPTH];
    logic [31:0] tlb_used  [DEPTH];
    logic [31:0] event_count;
    int unsigned tlb_count;

    t_xlate_result pending_results[$];
    logic [31:0]   addr_pool[POOL_SIZE];

    int unsigned errors = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned hits_seen = 0;
    int unsigned evictions_seen = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_request = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    logic        released = 1'b0;

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
        errors++;
    endtask

    function automatic void reset_shadow();
        sh_page_size  = 17'd64;
        sh_entries_pt = 11'd4;
        sh_limit      = 5'd4;
        sh_policy     = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            tlb_valid[i]  = 1'b0;
            tlb_page[i]   = '0;
            tlb_frame[i]  = '0;
            tlb_loaded[i] = '0;
            tlb_used[i]   = '0;
        end
        event_count = 32'd1;
        tlb_count   = 0;
    endfunction

    // Oldest entry by load time (FIFO) or by last use, ties by load (LRU)
    function automatic int choose_victim();
        int  best;
        logic older;
        best = -1;
        for (int i = 0; i < DEPTH; i++) begin
            if (!tlb_valid[i]) continue;
            if (best < 0) begin
                best = i;
                continue;
            end
            if (!sh_policy || tlb_used[i] == tlb_used[best])
                older = tlb_loaded[i] < tlb_loaded[best];
            else
                older = tlb_used[i] < tlb_used[best];
            if (older) best = i;
        end
        return best;
    endfunction

    // Work out the result of one action and advance the shadow TLB
    function automatic t_xlate_result translate_step(input t_action act,
            input logic [31:0] addr, input logic [19:0] frm);
        t_xlate_result r;
        logic [31:0] psz, ept, lim, pg;
        int slot;
        r = '0;
        if (act == ACT_FLUSH) begin
            for (int i = 0; i < DEPTH; i++) tlb_valid[i] = 1'b0;
            tlb_count = 0;
            return r;
        end
        if (act == ACT_NONE) return r;
        psz = (sh_page_size == 0) ? 1 : (sh_page_size > 65536) ? 65536 : sh_page_size;
        ept = (sh_entries_pt == 0) ? 1 : (sh_entries_pt > 1024) ? 1024 : sh_entries_pt;
        lim = (sh_limit == 0) ? 1 : (sh_limit > DEPTH) ? DEPTH : sh_limit;
        pg  = addr / psz;
        r.page       = pg;
        r.offset     = 16'(addr % psz);
        r.first_idx  = pg / ept;
        r.second_idx = 10'(pg % ept);
        slot = -1;
        for (int i = 0; i < DEPTH; i++)
            if (slot < 0 && tlb_valid[i] && tlb_page[i] == pg) slot = i;
        if (act == ACT_TRANSLATE) begin
            if (slot >= 0) begin
                tlb_used[slot] = event_count;
                r.hit   = 1'b1;
                r.frame = tlb_frame[slot];
            end
        end else begin
            if (slot < 0 && tlb_count < lim) begin
                for (int i = 0; i < DEPTH; i++)
                    if (slot < 0 && !tlb_valid[i]) slot = i;
                if (slot >= 0) tlb_count++;
            end
            if (slot < 0) begin
                slot = choose_victim();
                r.ev_valid = 1'b1;
                r.ev_page  = tlb_page[slot];
            end
            tlb_valid[slot]  = 1'b1;
            tlb_page[slot]   = pg;
            tlb_frame[slot]  = frm;
            tlb_loaded[slot] = event_count;
            tlb_used[slot]   = '0;
            r.hit   = 1'b1;
            r.frame = frm;
        end
        event_count = event_count + 1;
        if (r.hit) r.phys = 32'(r.frame) * psz + 32'(r.offset);
        return r;
    endfunction

    // Offer one item, wait for the transfer, then record what must come back
    task automatic send_item(input t_action act, input logic [31:0] addr,
                             input logic [19:0] frm, output logic was_hit);
        t_xlate_result r;
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge i_clk);
        end
        in_ch.valid           = 1'b1;
        in_ch.action          = act;
        in_ch.logical_address = addr;
        in_ch.frame_in        = frm;
        do @(posedge i_clk); while (!in_ch.ready);
        r = translate_step(act, addr, frm);
        pending_results.push_back(r);
        was_hit = r.hit;
        items_sent++;
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [16:0] value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_PAGE_SIZE:  sh_page_size  = value;
            CFG_ENTRIES_PT: sh_entries_pt = value[10:0];
            CFG_TLB_LIMIT:  sh_limit      = value[4:0];
            CFG_POLICY:     sh_policy     = value[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Drain every outstanding result, then let the block settle
    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [16:0] psz, input logic [16:0] ept,
                              input logic [16:0] lim, input logic pol);
        wait_drained();
        write_reg(CFG_PAGE_SIZE, psz);
        write_reg(CFG_ENTRIES_PT, ept);
        write_reg(CFG_TLB_LIMIT, lim);
        write_reg(CFG_POLICY, {16'd0, pol});
    endtask

    // Receiver: random stalls, plus a long hold-off when asked for one
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (!released) begin
            out_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each returned result with the oldest one recorded
    always @(posedge i_clk) begin
        t_xlate_result want;
        if (out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("[%0t] result arrived with nothing outstanding", $time);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (out_ch.hit) hits_seen++;
                if (out_ch.evicted_valid) evictions_seen++;
                if (out_ch.hit !== want.hit)
                    report_mismatch("hit", out_ch.hit, want.hit);
                if (out_ch.frame !== want.frame)
                    report_mismatch("frame", out_ch.frame, want.frame);
                if (out_ch.physical_address !== want.phys)
                    report_mismatch("physical_address", out_ch.physical_address, want.phys);
                if (out_ch.page_number !== want.page)
                    report_mismatch("page_number", out_ch.page_number, want.page);
                if (out_ch.first_level_index !== want.first_idx)
                    report_mismatch("first_level_index", out_ch.first_level_index,
                                    want.first_idx);
                if (out_ch.second_level_index !== want.second_idx)
                    report_mismatch("second_level_index", out_ch.second_level_index,
                                    want.second_idx);
                if (out_ch.offset !== want.offset)
                    report_mismatch("offset", out_ch.offset, want.offset);
                if (out_ch.evicted_valid !== want.ev_valid)
                    report_mismatch("evicted_valid", out_ch.evicted_valid, want.ev_valid);
                if (out_ch.evicted_page !== want.ev_page)
                    report_mismatch("evicted_page", out_ch.evicted_page, want.ev_page);
            end
        end
    end

    // Watchdog: give up after a long run of cycles with no transfer at all
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready) || !released)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_MAX) begin
            $display("[%0t] no transfer for %0d cycles", $time, STALL_MAX);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Directed: field extremes, every action, clamped registers, rewrite in place
    task automatic test_directed();
        logic h;
        send_item(ACT_TRANSLATE, 32'h0, 20'h0, h);           // cold miss
        send_item(ACT_FILL, 32'h0, 20'hFFFFF, h);
        send_item(ACT_TRANSLATE, 32'h3F, 20'h0, h);           // hit, top offset
        send_item(ACT_TRANSLATE, 32'hFFFFFFFF, 20'hFFFFF, h); // miss at top
        send_item(ACT_FILL, 32'hFFFFFFFF, 20'h0, h);
        send_item(ACT_FILL, 32'hFFFFFFC0, 20'hABCDE, h);      // rewrite in place
        send_item(ACT_TRANSLATE, 32'hFFFFFFFF, 20'h0, h);
        send_item(ACT_NONE, 32'hFFFFFFFF, 20'hFFFFF, h);      // ignored action
        for (int i = 1; i <= 4; i++)                          // fill past the limit
            send_item(ACT_FILL, 32'h40 * i, 20'(i), h);
        send_item(ACT_FLUSH, 32'h12345678, 20'h5, h);
        send_item(ACT_TRANSLATE, 32'h0, 20'h0, h);            // miss after flush
        // zero registers act as one, oversized ones clamp
        set_config(17'd0, 17'd0, 17'd0, 1'b1);
        send_item(ACT_FILL, 32'h5, 20'h7, h);
        send_item(ACT_FILL, 32'h6, 20'h8, h);                 // replaces at limit one
        set_config(17'h1FFFF, 17'h7FF, 17'h1F, 1'b0);
        send_item(ACT_FILL, 32'hFFFFFFFF, 20'hFFFFF, h);
        send_item(ACT_TRANSLATE, 32'hFFFF0000, 20'h0, h);
        set_config(17'd65536, 17'd1024, 17'd16, 1'b1);
        for (int i = 0; i < 3; i++)
            send_item(ACT_FILL, 32'h10000 * i, 20'(i + 9), h);
        // lower the limit under the valid count, then fill
        set_config(17'd65536, 17'd1024, 17'd1, 1'b1);
        send_item(ACT_FILL, 32'h7FFF0000, 20'h1, h);
        send_item(ACT_TRANSLATE, 32'h10000, 20'h0, h);
    endtask

    // Mostly well-formed miss/fill/retranslate sequences over a small page pool
    task automatic run_random(input int unsigned count);
        logic        h;
        logic [31:0] a;
        int unsigned pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            a = addr_pool[$urandom_range(POOL_SIZE - 1)] ^ 32'($urandom_range(255));
            if (pick < 80) begin
                send_item(ACT_TRANSLATE, a, 20'h0, h);
                if (!h) begin
                    send_item(ACT_FILL, a, 20'($urandom), h);
                    if ($urandom_range(1)) send_item(ACT_TRANSLATE, a, 20'h0, h);
                end
            end else if (pick < 90) begin
                send_item(ACT_FILL, a, 20'($urandom), h);
            end else if (pick < 95) begin
                send_item(ACT_TRANSLATE, $urandom, 20'($urandom), h);
            end else if (pick < 98) begin
                send_item(ACT_FLUSH, $urandom, 20'($urandom), h);
            end else begin
                send_item(ACT_NONE, $urandom, 20'($urandom), h);
            end
        end
    endtask

    function automatic logic [16:0] random_page_size();
        if ($urandom_range(1)) return 17'd1 << $urandom_range(16);
        return 17'($urandom_range(65536, 1));
    endfunction

    task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int unsigned count);
        set_config(random_page_size(), 17'($urandom_range(1024, 1)),
                   17'($urandom_range(16, 1)), 1'($urandom_range(1)));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        run_random(count);
    endtask

    // Hold the receiver off for a long stretch while items keep coming
    task automatic test_backpressure();
        set_config(17'd4096, 17'd16, 17'd8, 1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = HOLD_LEN;
        run_random(30);
    endtask

    initial begin
        in_ch.valid           = 1'b0;
        in_ch.action          = ACT_TRANSLATE;
        in_ch.logical_address = '0;
        in_ch.frame_in        = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = CFG_PAGE_SIZE;
        cfg_ch.data           = '0;
        reset_shadow();
        for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
        repeat (12) @(negedge i_clk);
        i_rst_n  = 1'b1;
        released = 1'b1;

        test_directed();
        test_random_phase(0, 0, 220);
        test_random_phase(79, 0, 200);
        test_random_phase(0, 79, 200);
        test_random_phase(25, 25, 200);
        test_backpressure();
        test_random_phase(0, 0, 150);

        wait_drained();
        $display("Sent %0d items over directed, random and back-pressure phases;", items_sent);
        $display("checked %0d results with %0d frames known and %0d evictions.",
                 results_seen, hits_seen, evictions_seen);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
